>>> hw/rtl/assert_macros.svh
// ---------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the RTL.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside reset.
`define ASSERT_CLK(lbl, clk, rstn, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checked on every clock edge, reset included.
`define ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

>>> hw/rtl/cle_pkg.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Console line editor package
// Microcode word format, control program, message text and shared types.
// ---------------------------------------------------------------------------
package cle_pkg;

    localparam int LINE_CAPACITY_DEF = 32;

    localparam int MSG_LEN   = 22;
    localparam int MSG_IDX_W = $clog2(MSG_LEN);

    localparam logic [7:0] CH_BS    = 8'h08;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_DEL   = 8'h7F;

    localparam int UPC_W = 4;

    // microcode entry points
    localparam logic [UPC_W-1:0] U_IDLE   = 4'd0;
    localparam logic [UPC_W-1:0] U_DECODE = 4'd1;
    localparam logic [UPC_W-1:0] U_ECHO   = 4'd2;
    localparam logic [UPC_W-1:0] U_RUB0   = 4'd3;
    localparam logic [UPC_W-1:0] U_RUB1   = 4'd4;
    localparam logic [UPC_W-1:0] U_RUB2   = 4'd5;
    localparam logic [UPC_W-1:0] U_ERR0   = 4'd6;
    localparam logic [UPC_W-1:0] U_ERR1   = 4'd7;
    localparam logic [UPC_W-1:0] U_EOL0   = 4'd8;
    localparam logic [UPC_W-1:0] U_EOL1   = 4'd9;
    localparam logic [UPC_W-1:0] U_RD     = 4'd10;
    localparam logic [UPC_W-1:0] U_LINE   = 4'd11;
    localparam logic [UPC_W-1:0] U_LAST   = U_LINE;

    localparam logic [1:0] BYTE_RX    = 2'd0;
    localparam logic [1:0] BYTE_CONST = 2'd1;
    localparam logic [1:0] BYTE_MSG   = 2'd2;
    localparam logic [1:0] BYTE_STORE = 2'd3;

    localparam logic [1:0] LAST_NO  = 2'd0;
    localparam logic [1:0] LAST_YES = 2'd1;
    localparam logic [1:0] LAST_CNT = 2'd2;

    localparam logic [1:0] LEN_KEEP     = 2'd0;
    localparam logic [1:0] LEN_INC      = 2'd1;
    localparam logic [1:0] LEN_DEC      = 2'd2;
    localparam logic [1:0] LEN_CLR_DONE = 2'd3;

    localparam logic [1:0] IDX_KEEP = 2'd0;
    localparam logic [1:0] IDX_CLR  = 2'd1;
    localparam logic [1:0] IDX_INC  = 2'd2;

    localparam logic [2:0] JMP_NEXT     = 3'd0;
    localparam logic [2:0] JMP_ALWAYS   = 3'd1;
    localparam logic [2:0] JMP_ACCEPT   = 3'd2;
    localparam logic [2:0] JMP_DISPATCH = 3'd3;
    localparam logic [2:0] JMP_LOOP     = 3'd4;

    typedef struct packed {
        logic             take;
        logic             emit;
        logic [1:0]       byte_sel;
        logic [7:0]       const_byte;
        logic             kind;
        logic [1:0]       last_sel;
        logic [1:0]       len_op;
        logic             store_wr;
        logic [1:0]       idx_op;
        logic             mem_rd;
        logic [2:0]       jump;
        logic [UPC_W-1:0] target;
    } uword_t;

    typedef struct packed {
        uword_t word;
        logic   go;
    } ctrl_t;

    typedef struct packed {
        logic slot_free;
        logic is_eol;
        logic is_rub;
        logic is_print;
        logic len_zero;
        logic len_full;
        logic cnt_done;
    } status_t;

    function automatic uword_t ucode_rom(input logic [UPC_W-1:0] addr);
        uword_t w;
        w = '0;
        case (addr)
            U_IDLE: begin
                w.take = 1'b1;
                w.jump = JMP_ACCEPT;
            end
            U_DECODE: begin
                w.jump = JMP_DISPATCH;
            end
            U_ECHO: begin
                w.emit     = 1'b1;
                w.byte_sel = BYTE_RX;
                w.last_sel = LAST_YES;
                w.len_op   = LEN_INC;
                w.store_wr = 1'b1;
                w.jump     = JMP_ALWAYS;
                w.target   = U_IDLE;
            end
            U_RUB0: begin
                w.emit       = 1'b1;
                w.byte_sel   = BYTE_CONST;
                w.const_byte = CH_BS;
                w.jump       = JMP_NEXT;
            end
            U_RUB1: begin
                w.emit       = 1'b1;
                w.byte_sel   = BYTE_CONST;
                w.const_byte = CH_SPACE;
                w.jump       = JMP_NEXT;
            end
            U_RUB2: begin
                w.emit       = 1'b1;
                w.byte_sel   = BYTE_CONST;
                w.const_byte = CH_BS;
                w.last_sel   = LAST_YES;
                w.len_op     = LEN_DEC;
                w.jump       = JMP_ALWAYS;
                w.target     = U_IDLE;
            end
            U_ERR0: begin
                w.len_op = LEN_CLR_DONE;
                w.idx_op = IDX_CLR;
                w.jump   = JMP_NEXT;
            end
            U_ERR1: begin
                w.emit     = 1'b1;
                w.byte_sel = BYTE_MSG;
                w.last_sel = LAST_CNT;
                w.idx_op   = IDX_INC;
                w.jump     = JMP_LOOP;
                w.target   = U_ERR1;
            end
            U_EOL0: begin
                w.emit       = 1'b1;
                w.byte_sel   = BYTE_CONST;
                w.const_byte = CH_CR;
                w.idx_op     = IDX_CLR;
                w.jump       = JMP_NEXT;
            end
            U_EOL1: begin
                w.emit       = 1'b1;
                w.byte_sel   = BYTE_CONST;
                w.const_byte = CH_LF;
                w.jump       = JMP_NEXT;
            end
            U_RD: begin
                w.mem_rd = 1'b1;
                w.jump   = JMP_NEXT;
            end
            U_LINE: begin
                w.emit     = 1'b1;
                w.byte_sel = BYTE_STORE;
                w.kind     = 1'b1;
                w.last_sel = LAST_CNT;
                w.len_op   = LEN_CLR_DONE;
                w.idx_op   = IDX_INC;
                w.jump     = JMP_LOOP;
                w.target   = U_RD;
            end
            default: begin
                w.jump   = JMP_ALWAYS;
                w.target = U_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] msg_byte(input logic [MSG_IDX_W-1:0] idx);
        logic [7:0] b;
        case (idx)
            5'd0:    b = CH_CR;
            5'd1:    b = CH_LF;
            5'd2:    b = "e";
            5'd3:    b = "r";
            5'd4:    b = "r";
            5'd5:    b = ":";
            5'd6:    b = " ";
            5'd7:    b = "l";
            5'd8:    b = "i";
            5'd9:    b = "n";
            5'd10:   b = "e";
            5'd11:   b = " ";
            5'd12:   b = "t";
            5'd13:   b = "o";
            5'd14:   b = "o";
            5'd15:   b = " ";
            5'd16:   b = "l";
            5'd17:   b = "o";
            5'd18:   b = "n";
            5'd19:   b = "g";
            5'd20:   b = CH_CR;
            5'd21:   b = CH_LF;
            default: b = CH_LF;
        endcase
        return b;
    endfunction

endpackage

>>> hw/rtl/cle_sequencer.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Console line editor sequencer
// Micro-PC, control ROM lookup, stall gating and jump resolution.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_sequencer (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             s_valid,
    input  cle_pkg::status_t status,
    output cle_pkg::ctrl_t   ctrl
);
    import cle_pkg::*;

    logic [UPC_W-1:0] upc_reg;
    logic [UPC_W-1:0] upc_next;
    logic [UPC_W-1:0] dispatch;
    uword_t           word;
    logic             go;

    assign word = ucode_rom(upc_reg);
    assign go   = !(word.emit && !status.slot_free);

    assign ctrl.word = word;
    assign ctrl.go   = go;

    always_comb begin
        if (status.is_eol && !status.len_zero) begin
            dispatch = U_EOL0;
        end else if (status.is_rub && !status.len_zero) begin
            dispatch = U_RUB0;
        end else if (status.is_print && !status.len_full) begin
            dispatch = U_ECHO;
        end else if (status.is_print) begin
            dispatch = U_ERR0;
        end else begin
            dispatch = U_IDLE;
        end
    end

    always_comb begin
        upc_next = upc_reg;
        if (go) begin
            case (word.jump)
                JMP_NEXT:     upc_next = upc_reg + 1'b1;
                JMP_ALWAYS:   upc_next = word.target;
                JMP_ACCEPT:   upc_next = s_valid ? upc_reg + 1'b1 : upc_reg;
                JMP_DISPATCH: upc_next = dispatch;
                JMP_LOOP:     upc_next = status.cnt_done ? U_IDLE : word.target;
                default:      upc_next = U_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            upc_reg <= U_IDLE;
        end else begin
            upc_reg <= upc_next;
        end
    end

    `ASSERT_CLK(a_upc_range, aclk, aresetn, upc_reg <= U_LAST, "micro-PC out of program")
    `ASSERT_CLK(a_stall_hold, aclk, aresetn,
                (word.emit && !status.slot_free) |=> (upc_reg == $past(upc_reg)),
                "sequencer advanced while output slot busy")

endmodule

>>> hw/rtl/cle_datapath.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Console line editor datapath
// Received byte, line store, length and index counters, output register.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module cle_datapath #(
    parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  cle_pkg::ctrl_t   ctrl,
    output cle_pkg::status_t status,
    input  logic             s_valid,
    input  logic [7:0]       s_rx_byte,
    output logic             m_valid,
    input  logic             m_ready,
    output logic [7:0]       m_out_byte,
    output logic             m_out_kind,
    output logic             m_last
);
    import cle_pkg::*;

    localparam int LEN_W = $clog2(LINE_CAPACITY);
    localparam int IDX_W = (LEN_W > MSG_IDX_W) ? LEN_W : MSG_IDX_W;
    localparam logic [LEN_W-1:0] LEN_FULL = LEN_W'(LINE_CAPACITY - 1);
    localparam logic [IDX_W-1:0] MSG_END  = IDX_W'(MSG_LEN - 1);

    logic [7:0]       store_mem [LINE_CAPACITY];
    logic [7:0]       rd_data_reg;
    logic [7:0]       rx_reg;
    logic [LEN_W-1:0] len_reg;
    logic [LEN_W-1:0] len_next;
    logic [LEN_W-1:0] len_m1;
    logic [IDX_W-1:0] idx_reg;
    logic [IDX_W-1:0] idx_next;
    logic             m_valid_reg;
    logic [7:0]       m_byte_reg;
    logic             m_kind_reg;
    logic             m_last_reg;
    logic [7:0]       byte_sel;
    logic             last_sel;
    logic             cnt_done;
    logic             fire;

    assign fire   = ctrl.go;
    assign len_m1 = len_reg - 1'b1;

    always_comb begin
        if (ctrl.word.byte_sel == BYTE_MSG) begin
            cnt_done = (idx_reg == MSG_END);
        end else begin
            cnt_done = (idx_reg == IDX_W'(len_m1));
        end
    end

    assign status.slot_free = !m_valid_reg || m_ready;
    assign status.is_eol    = (rx_reg == CH_CR) || (rx_reg == CH_LF);
    assign status.is_rub    = (rx_reg == CH_BS) || (rx_reg == CH_DEL);
    assign status.is_print  = (rx_reg >= CH_SPACE) && (rx_reg < CH_DEL);
    assign status.len_zero  = (len_reg == '0);
    assign status.len_full  = (len_reg == LEN_FULL);
    assign status.cnt_done  = cnt_done;

    always_comb begin
        case (ctrl.word.byte_sel)
            BYTE_RX:    byte_sel = rx_reg;
            BYTE_CONST: byte_sel = ctrl.word.const_byte;
            BYTE_MSG:   byte_sel = msg_byte(idx_reg[MSG_IDX_W-1:0]);
            BYTE_STORE: byte_sel = rd_data_reg;
            default:    byte_sel = rx_reg;
        endcase
    end

    always_comb begin
        case (ctrl.word.last_sel)
            LAST_NO:  last_sel = 1'b0;
            LAST_YES: last_sel = 1'b1;
            LAST_CNT: last_sel = cnt_done;
            default:  last_sel = 1'b0;
        endcase
    end

    always_comb begin
        len_next = len_reg;
        if (fire) begin
            case (ctrl.word.len_op)
                LEN_KEEP:     len_next = len_reg;
                LEN_INC:      len_next = len_reg + 1'b1;
                LEN_DEC:      len_next = len_m1;
                LEN_CLR_DONE: len_next = (ctrl.word.jump == JMP_LOOP && !cnt_done) ?
                                         len_reg : '0;
                default:      len_next = len_reg;
            endcase
        end
    end

    always_comb begin
        idx_next = idx_reg;
        if (fire) begin
            case (ctrl.word.idx_op)
                IDX_KEEP: idx_next = idx_reg;
                IDX_CLR:  idx_next = '0;
                IDX_INC:  idx_next = idx_reg + 1'b1;
                default:  idx_next = idx_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            len_reg     <= '0;
            idx_reg     <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            len_reg <= len_next;
            idx_reg <= idx_next;
            if (fire && ctrl.word.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.word.take && s_valid) begin
            rx_reg <= s_rx_byte;
        end
        if (fire && ctrl.word.emit) begin
            m_byte_reg <= byte_sel;
            m_kind_reg <= ctrl.word.kind;
            m_last_reg <= last_sel;
        end
    end

    always_ff @(posedge aclk) begin
        if (fire && ctrl.word.store_wr) begin
            store_mem[len_reg] <= rx_reg;
        end
        if (fire && ctrl.word.mem_rd) begin
            rd_data_reg <= store_mem[idx_reg[LEN_W-1:0]];
        end
    end

    assign m_valid    = m_valid_reg;
    assign m_out_byte = m_byte_reg;
    assign m_out_kind = m_kind_reg;
    assign m_last     = m_last_reg;

    `ASSERT_CLK(a_len_range, aclk, aresetn, len_reg <= LEN_FULL, "line length past capacity")
    `ASSERT_CLK(a_line_end_clears, aclk, aresetn,
                (m_valid_reg && m_kind_reg && m_last_reg) |-> (len_reg == '0),
                "line handed out but length not cleared")

endmodule

>>> hw/rtl/console_line_editor_unit.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// Console line editor unit
// Edits a terminal line byte by byte with echo; hands out completed lines.
//
//   channel  dir  ports                               handshake
//   s_       in   s_rx_byte                           s_valid / s_ready
//   m_       out  m_out_byte, m_out_kind, m_last      m_valid / m_ready
//
// One request at a time, run by a 12-step microprogram, one step a cycle except while waiting for input or output.
// Accept is followed by decode; ignored bytes end there.
// Printable byte: echo. Rubout: BS, space, BS. Line-too-long: clear the line, then the message.
// Line end: CR, LF, then per stored byte a registered store read, then emit.
// Any step that emits waits while the output register is full and not taken.
// Reset clears the sequencer, line length and output valid; the store is not cleared.
// ---------------------------------------------------------------------------
module console_line_editor_unit #(
    parameter int LINE_CAPACITY = cle_pkg::LINE_CAPACITY_DEF
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_rx_byte,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_out_byte,
    output logic       m_out_kind,
    output logic       m_last
);
    import cle_pkg::*;

    ctrl_t   ctrl;
    status_t status;

    cle_sequencer u_seq (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .status  (status),
        .ctrl    (ctrl)
    );

    cle_datapath #(
        .LINE_CAPACITY (LINE_CAPACITY)
    ) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .ctrl       (ctrl),
        .status     (status),
        .s_valid    (s_valid),
        .s_rx_byte  (s_rx_byte),
        .m_valid    (m_valid),
        .m_ready    (m_ready),
        .m_out_byte (m_out_byte),
        .m_out_kind (m_out_kind),
        .m_last     (m_last)
    );

    assign s_ready = ctrl.word.take;

endmodule
